>>> src/ple_pkg.sv
// Package: shared types and codes for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

  localparam int SlotW = 8;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [SlotW-1:0] slot;
  } cmd_t;

  // request outcome handed to the output stage
  typedef struct packed {
    status_e status;
    logic    rd_en;
  } res_t;

endpackage

>>> src/ple_cell.sv
// One storage cell of the list chain: holds a single slot, shifts with its neighbours.
`timescale 1ns / 1ps
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  localparam logic [SlotW-1:0] IdxC = SlotW'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (IdxC > cmd_i.slot) begin
        data_d = left_i;
      end else if (IdxC == cmd_i.slot) begin
        data_d = value_i;
      end
    end else if (cmd_i.del) begin
      if (IdxC >= cmd_i.slot) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (IdxC == cmd_i.slot) ? data_q : '0;

endmodule

>>> src/ple_ctrl.sv
// Controller: element count, request checks and shift commands for the chain.
`timescale 1ns / 1ps
module ple_ctrl
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         beat_i,
  input  req_e                         req_i,
  input  logic [SlotW-1:0]             position_i,
  output cmd_t                         cmd_o,
  output res_t                         res_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > SlotW ? CntW : SlotW) + 1;

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] pos_c, cnt_c, depth_c;
  logic            pos_zero;

  assign pos_c    = CmpW'(position_i);
  assign cnt_c    = CmpW'(count_q);
  assign depth_c  = CmpW'(DEPTH);
  assign pos_zero = (position_i == '0);

  always_comb begin
    res_o.status = ST_OK;
    res_o.rd_en  = 1'b0;
    cmd_o.ins    = 1'b0;
    cmd_o.del    = 1'b0;
    cmd_o.slot   = position_i - SlotW'(1);
    count_d      = count_q;
    case (req_i)
      REQ_INSERT: begin
        if (cnt_c >= depth_c) begin
          res_o.status = ST_FULL;
        end else if (pos_zero || pos_c > cnt_c + CmpW'(1)) begin
          res_o.status = ST_BADPOS;
        end else begin
          cmd_o.ins = beat_i;
          count_d   = count_q + CntW'(1);
        end
      end
      REQ_DELETE: begin
        if (pos_zero || pos_c > cnt_c) begin
          res_o.status = ST_BADPOS;
        end else begin
          res_o.rd_en = 1'b1;
          cmd_o.del   = beat_i;
          count_d     = count_q - CntW'(1);
        end
      end
      REQ_GET: begin
        if (pos_zero || pos_c > cnt_c) begin
          res_o.status = ST_BADPOS;
        end else begin
          res_o.rd_en = 1'b1;
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (beat_i) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

endmodule

>>> src/positional_list_engine_top.sv
// Top level: ordered list of up to DEPTH elements held in a chain of shifting cells.
// The result beat is registered: it is offered on the output in the cycle after the input beat.
// One request per cycle unless the output stalls; every cell shifts in the same edge.
// Reset: rst_ni clears the element count and the result valid flag; cell data is not reset.
`timescale 1ns / 1ps
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // position[7:0], value_in[39:8]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value_out[31:0], length[36:32], is_empty[37], zero
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic                  beat;
  cmd_t                  cmd;
  res_t                  res;
  logic [CntW-1:0]       count_nx;
  logic [63:0]           val_ext;
  logic [DATA_WIDTH-1:0] val_in;
  logic [DATA_WIDTH-1:0] data [DEPTH];
  logic [DATA_WIDTH-1:0] rd   [DEPTH];
  logic [DATA_WIDTH-1:0] rd_any;
  logic [63:0]           rd_ext;
  logic [15:0]           cnt_ext;

  logic        valid_q;
  logic [1:0]  status_q;
  logic [31:0] value_q;
  logic [4:0]  length_q;
  logic        empty_q;

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;

  assign val_ext = {32'b0, s_axis_tdata[39:8]};
  assign val_in  = val_ext[DATA_WIDTH-1:0];

  ple_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (beat),
    .req_i      (req_e'(s_axis_tuser)),
    .position_i (s_axis_tdata[7:0]),
    .cmd_o      (cmd),
    .res_o      (res),
    .count_o    (count_nx)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = data[i];
    end else begin : g_inner
      assign right = data[i+1];
    end
    ple_cell #(
      .IDX       (i),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (val_in),
      .left_i  (left),
      .right_i (right),
      .data_o  (data[i]),
      .rd_o    (rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | rd[i];
    end
  end

  assign rd_ext  = 64'(rd_any);
  assign cnt_ext = 16'(count_nx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      status_q <= res.status;
      value_q  <= res.rd_en ? rd_ext[31:0] : 32'b0;
      length_q <= cnt_ext[4:0];
      empty_q  <= (count_nx == '0);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {2'b0, empty_q, length_q, value_q};

endmodule

>>> tb/sv/positional_list_engine_top_tb.sv
// Testbench: random and directed stream traffic into the positional list engine, scored beat by beat.
`timescale 1ns / 1ps
module positional_list_engine_top_tb;
  import ple_pkg::*;

  localparam int ListDepth = 16;
  localparam int DataW     = 32;
  localparam int RandomReqs = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // position[7:0], value_in[39:8]
  logic [1:0]  s_axis_tuser;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // value_out[31:0], length[36:32], is_empty[37], zero
  logic [1:0]  m_axis_tuser;   // status[1:0]

  bit calm;        // no idling on either side
  bit long_hold;   // receiver to hold off for a long stretch

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] value;
    logic [4:0]       length;
    logic             empty;
  } list_reply_t;

  class list_scoreboard;
    logic [DataW-1:0] cells [ListDepth];
    int unsigned      count;
    list_reply_t      awaited_replies[$];
    int unsigned      mismatches;
    int unsigned      op_seen [4];
    int unsigned      n_full, n_badpos, n_ok, peak_len;

    function void note_request(req_e op, logic [7:0] pos, logic [DataW-1:0] val);
      list_reply_t rep;
      int          k;
      rep = '{status: ST_OK, value: '0, length: '0, empty: 1'b0};
      op_seen[op]++;
      case (op)
        REQ_INSERT: begin
          if (count >= ListDepth) rep.status = ST_FULL;
          else if (pos == 0 || pos > count + 1) rep.status = ST_BADPOS;
          else begin
            for (k = count; k >= pos; k--) cells[k] = cells[k-1];
            cells[pos-1] = val;
            count++;
          end
        end
        REQ_DELETE: begin
          if (pos == 0 || pos > count) rep.status = ST_BADPOS;
          else begin
            rep.value = cells[pos-1];
            for (k = pos; k < count; k++) cells[k-1] = cells[k];
            count--;
          end
        end
        REQ_GET: begin
          if (pos == 0 || pos > count) rep.status = ST_BADPOS;
          else rep.value = cells[pos-1];
        end
        default: count = 0;
      endcase
      rep.length = count[4:0];
      rep.empty  = (count == 0);
      if (count > peak_len) peak_len = count;
      case (rep.status)
        ST_FULL:   n_full++;
        ST_BADPOS: n_badpos++;
        default:   n_ok++;
      endcase
      awaited_replies.push_back(rep);
    endfunction

    function void check_reply(logic [1:0] st, logic [DataW-1:0] val, logic [4:0] len,
                              logic emp);
      list_reply_t exp_rep;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d value %h length %0d empty %b",
                 $time, st, val, len, emp);
        mismatches++;
        return;
      end
      exp_rep = awaited_replies.pop_front();
      if (st !== exp_rep.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, exp_rep.status, st);
        mismatches++;
      end
      if (val !== exp_rep.value) begin
        $display("%0t: value mismatch: expected %h actual %h", $time, exp_rep.value, val);
        mismatches++;
      end
      if (len !== exp_rep.length) begin
        $display("%0t: length mismatch: expected %0d actual %0d", $time, exp_rep.length, len);
        mismatches++;
      end
      if (emp !== exp_rep.empty) begin
        $display("%0t: empty flag mismatch: expected %b actual %b", $time, exp_rep.empty, emp);
        mismatches++;
      end
    endfunction
  endclass

  list_scoreboard sb = new();

  positional_list_engine_top #(
    .DEPTH      (ListDepth),
    .DATA_WIDTH (DataW)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // one request beat, with an occasional idle burst in front of it
  task automatic issue_request(input req_e op, input logic [7:0] pos,
                               input logic [DataW-1:0] val);
    if (!calm && !long_hold && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, pos};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_request(op, pos, val);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_reply(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32], m_axis_tdata[37]);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          sent;
    int          mode;
    int          burst;
    int          roll;
    int          lim;
    req_e        op;
    logic [7:0]  pos;
    logic [31:0] val;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_CLEAR;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-list corners, bad positions, front/middle/back
    issue_request(REQ_CLEAR,  8'd1,   32'h0);
    issue_request(REQ_DELETE, 8'd1,   32'h0);
    issue_request(REQ_GET,    8'd1,   32'h0);
    issue_request(REQ_INSERT, 8'd0,   32'h1234_5678);
    issue_request(REQ_INSERT, 8'd2,   32'h1234_5678);
    issue_request(REQ_INSERT, 8'd1,   32'h0000_0000);
    issue_request(REQ_INSERT, 8'd2,   32'hFFFF_FFFF);
    issue_request(REQ_INSERT, 8'd2,   32'hA5A5_5A5A);
    issue_request(REQ_INSERT, 8'd1,   32'h0000_0001);
    issue_request(REQ_GET,    8'd0,   32'h0);
    issue_request(REQ_GET,    8'd1,   32'h0);
    issue_request(REQ_GET,    8'd4,   32'h0);
    issue_request(REQ_GET,    8'd5,   32'h0);
    issue_request(REQ_GET,    8'd255, 32'h0);
    issue_request(REQ_INSERT, 8'd255, 32'hDEAD_BEEF);
    issue_request(REQ_INSERT, 8'd6,   32'hDEAD_BEEF);
    issue_request(REQ_DELETE, 8'd4,   32'h0);
    issue_request(REQ_DELETE, 8'd1,   32'h0);
    issue_request(REQ_DELETE, 8'd255, 32'h0);
    issue_request(REQ_DELETE, 8'd0,   32'h0);
    issue_request(REQ_DELETE, 8'd2,   32'h0);
    issue_request(REQ_CLEAR,  8'd0,   32'hFFFF_FFFF);
    issue_request(REQ_INSERT, 8'd1,   32'h8000_0000);
    issue_request(REQ_DELETE, 8'd1,   32'h0);
    issue_request(REQ_CLEAR,  8'd255, 32'h0);

    // random: episodes that fill, drain or mix, with some noise
    sent = 0;
    while (sent < RandomReqs) begin
      mode  = (sent == 0) ? 0 : $urandom_range(0, 2);
      burst = $urandom_range(10, 40);
      repeat (burst) begin
        if (sent == 150) long_hold = 1'b1;
        if (sent == 300) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (sb.awaited_replies.size() != 0);
        end
        if (sent == 560) calm = 1'b1;
        roll = $urandom_range(0, 99);
        case (mode)
          0:       op = (roll < 75) ? REQ_INSERT : (roll < 85) ? REQ_DELETE : REQ_GET;
          1:       op = (roll < 15) ? REQ_INSERT : (roll < 80) ? REQ_DELETE : REQ_GET;
          default: op = (roll < 34) ? REQ_INSERT : (roll < 67) ? REQ_DELETE : REQ_GET;
        endcase
        if ($urandom_range(0, 79) == 0) op = REQ_CLEAR;
        lim = (op == REQ_INSERT) ? sb.count + 1 : sb.count;
        roll = $urandom_range(0, 4);
        if ($urandom_range(0, 99) < 12 || lim == 0) pos = 8'($urandom_range(0, 255));
        else if (roll == 0) pos = 8'd1;
        else if (roll == 1) pos = 8'(lim);
        else pos = 8'($urandom_range(1, lim));
        roll = $urandom_range(0, 15);
        if (roll == 0) val = '0;
        else if (roll == 1) val = '1;
        else val = $urandom;
        issue_request(op, pos, val);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d inserts, %0d deletes, %0d gets, %0d clears; peak length %0d.",
             sb.op_seen[REQ_INSERT], sb.op_seen[REQ_DELETE], sb.op_seen[REQ_GET],
             sb.op_seen[REQ_CLEAR], sb.peak_len);
    $display("Replies: %0d ok, %0d bad position, %0d full; %0d field mismatches.",
             sb.n_ok, sb.n_badpos, sb.n_full, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited_replies.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
